FILE: rtl/vkp_pkg.sv
// ----------------------------------------------------------------------------
// vkp_pkg
// Types, byte codes and helper functions shared by the terminal key parser.
// ----------------------------------------------------------------------------
package vkp_pkg;

   // Top-level parse mode, one-hot.
   typedef enum logic [2:0] {
      MODE_PLAIN = 3'b001,
      MODE_ESC   = 3'b010,
      MODE_CSI   = 3'b100
   } parse_mode_type;

   // Field of an SGR mouse report that digits currently go to, one-hot.
   typedef enum logic [3:0] {
      PHASE_BUTTON = 4'b0001,
      PHASE_COL    = 4'b0010,
      PHASE_ROW    = 4'b0100,
      PHASE_STOP   = 4'b1000
   } mouse_phase_type;

   typedef enum logic [3:0] {
      KEY_ENTER     = 4'd0,
      KEY_BACKSPACE = 4'd1,
      KEY_TAB       = 4'd2,
      KEY_CTRL_C    = 4'd3,
      KEY_TEXT      = 4'd4,
      KEY_ESCAPE    = 4'd5,
      KEY_UP        = 4'd6,
      KEY_DOWN      = 4'd7,
      KEY_RIGHT     = 4'd8,
      KEY_LEFT      = 4'd9,
      KEY_HOME      = 4'd10,
      KEY_END       = 4'd11,
      KEY_DELETE    = 4'd12,
      KEY_MOUSE     = 4'd13
   } key_code_type;

   localparam logic [7:0] BYTE_ETX      = 8'h03;
   localparam logic [7:0] BYTE_BS       = 8'h08;
   localparam logic [7:0] BYTE_TAB      = 8'h09;
   localparam logic [7:0] BYTE_LF       = 8'h0A;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_ESC      = 8'h1B;
   localparam logic [7:0] BYTE_SPACE    = 8'h20;
   localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
   localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;
   localparam logic [7:0] BYTE_SEMI     = 8'h3B;
   localparam logic [7:0] BYTE_LT       = 8'h3C;
   localparam logic [7:0] BYTE_AT       = 8'h40;
   localparam logic [7:0] BYTE_UPPER_A  = 8'h41;
   localparam logic [7:0] BYTE_UPPER_B  = 8'h42;
   localparam logic [7:0] BYTE_UPPER_C  = 8'h43;
   localparam logic [7:0] BYTE_UPPER_D  = 8'h44;
   localparam logic [7:0] BYTE_UPPER_F  = 8'h46;
   localparam logic [7:0] BYTE_UPPER_H  = 8'h48;
   localparam logic [7:0] BYTE_UPPER_M  = 8'h4D;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
   localparam logic [7:0] BYTE_LOWER_M  = 8'h6D;
   localparam logic [7:0] BYTE_TILDE    = 8'h7E;
   localparam logic [7:0] BYTE_DEL      = 8'h7F;

   localparam logic [15:0] NUM_MAX = 16'hFFFF;

   // Incremental state of an open CSI sequence (the byte count lives apart,
   // since its width follows the capacity parameter).
   typedef struct packed {
      logic            starts_with_lt;
      logic [15:0]     tilde_number;
      logic            tilde_done;
      mouse_phase_type mouse_phase;
      logic [15:0]     acc_button;
      logic [15:0]     acc_col;
      logic [15:0]     acc_row;
   } csi_state_type;

   localparam csi_state_type CSI_CLEAR = '{
      starts_with_lt: 1'b0,
      tilde_number:   16'd0,
      tilde_done:     1'b0,
      mouse_phase:    PHASE_BUTTON,
      acc_button:     16'd0,
      acc_col:        16'd0,
      acc_row:        16'd0
   };

   typedef struct packed {
      key_code_type key_code;
      logic [7:0]   text_char;
      logic [15:0]  button_code;
      logic [15:0]  pointer_col;
      logic [15:0]  pointer_row;
      logic         is_release;
   } rsp_item_type;

   // acc * 10 + digit, saturating at the largest 16-bit value.
   function automatic logic [15:0] sat_digit(input logic [15:0] acc,
                                             input logic [3:0]  digit);
      logic [19:0] sum;
      sum = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(digit);
      return (sum > 20'(NUM_MAX)) ? NUM_MAX : sum[15:0];
   endfunction

endpackage

FILE: rtl/vkp_req_if.sv
// ----------------------------------------------------------------------------
// vkp_req_if
// Byte channel into the key parser: valid/ready handshake with one raw byte.
// ----------------------------------------------------------------------------
interface vkp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

FILE: rtl/vkp_rsp_if.sv
// ----------------------------------------------------------------------------
// vkp_rsp_if
// Event channel out of the key parser: valid/ready handshake with one event.
// ----------------------------------------------------------------------------
interface vkp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  key_code;
   logic [7:0]  text_char;
   logic [15:0] button_code;
   logic [15:0] pointer_col;
   logic [15:0] pointer_row;
   logic        is_release;

   modport source (output valid, output key_code, output text_char, output button_code,
                   output pointer_col, output pointer_row, output is_release,
                   input ready);
   modport sink   (input valid, input key_code, input text_char, input button_code,
                   input pointer_col, input pointer_row, input is_release,
                   output ready);
endinterface

FILE: rtl/vkp_step.sv
// ----------------------------------------------------------------------------
// vkp_step
// Next-state and event decode for one byte, given the current parser state.
// ----------------------------------------------------------------------------
module vkp_step #(
   parameter int CSI_CAPACITY = 32
) (
   input  logic [7:0]                     byte_in,
   input  vkp_pkg::parse_mode_type        mode,
   input  logic [$clog2(CSI_CAPACITY)-1:0] held,
   input  vkp_pkg::csi_state_type         csi,
   output vkp_pkg::parse_mode_type        mode_next,
   output logic [$clog2(CSI_CAPACITY)-1:0] held_next,
   output vkp_pkg::csi_state_type         csi_next,
   output logic                           emit,
   output vkp_pkg::rsp_item_type          item
);
   import vkp_pkg::*;

   localparam int HeldWidth = $clog2(CSI_CAPACITY);

   logic       is_digit;
   logic [3:0] digit_val;
   logic       is_final;
   logic       has_room;
   logic       lt_report;

   assign is_digit  = (byte_in >= BYTE_DIGIT_0) && (byte_in <= BYTE_DIGIT_9);
   assign digit_val = byte_in[3:0];
   assign is_final  = (byte_in >= BYTE_AT) && (byte_in <= BYTE_TILDE);
   assign has_room  = held < HeldWidth'(CSI_CAPACITY - 1);
   assign lt_report = csi.starts_with_lt && (held != '0);

   always_comb begin
      mode_next = mode;
      held_next = held;
      csi_next  = csi;
      emit      = 1'b0;
      item      = '{key_code: KEY_ENTER, text_char: 8'd0, button_code: 16'd0,
                    pointer_col: 16'd0, pointer_row: 16'd0, is_release: 1'b0};

      case (mode)
         MODE_PLAIN: begin
            if (byte_in == BYTE_ESC) begin
               mode_next = MODE_ESC;
            end else if (byte_in == BYTE_CR || byte_in == BYTE_LF) begin
               emit          = 1'b1;
               item.key_code = KEY_ENTER;
            end else if (byte_in == BYTE_BS || byte_in == BYTE_DEL) begin
               emit          = 1'b1;
               item.key_code = KEY_BACKSPACE;
            end else if (byte_in == BYTE_TAB) begin
               emit          = 1'b1;
               item.key_code = KEY_TAB;
            end else if (byte_in == BYTE_ETX) begin
               emit          = 1'b1;
               item.key_code = KEY_CTRL_C;
            end else if (byte_in >= BYTE_SPACE) begin
               emit           = 1'b1;
               item.key_code  = KEY_TEXT;
               item.text_char = byte_in;
            end
         end

         MODE_ESC: begin
            if (byte_in == BYTE_LBRACKET) begin
               mode_next = MODE_CSI;
               held_next = '0;
               csi_next  = CSI_CLEAR;
            end else begin
               mode_next     = MODE_PLAIN;
               emit          = 1'b1;
               item.key_code = KEY_ESCAPE;
            end
         end

         MODE_CSI: begin
            if (!has_room) begin
               // Sequence too long: drop it without an event.
               mode_next = MODE_PLAIN;
               held_next = '0;
            end else if (is_final) begin
               mode_next = MODE_PLAIN;
               held_next = '0;
               csi_next  = CSI_CLEAR;
               case (byte_in)
                  BYTE_UPPER_A: begin emit = 1'b1; item.key_code = KEY_UP;    end
                  BYTE_UPPER_B: begin emit = 1'b1; item.key_code = KEY_DOWN;  end
                  BYTE_UPPER_C: begin emit = 1'b1; item.key_code = KEY_RIGHT; end
                  BYTE_UPPER_D: begin emit = 1'b1; item.key_code = KEY_LEFT;  end
                  BYTE_UPPER_H: begin emit = 1'b1; item.key_code = KEY_HOME;  end
                  BYTE_UPPER_F: begin emit = 1'b1; item.key_code = KEY_END;   end
                  BYTE_TILDE: begin
                     if (csi.tilde_number == 16'd1 || csi.tilde_number == 16'd7) begin
                        emit          = 1'b1;
                        item.key_code = KEY_HOME;
                     end else if (csi.tilde_number == 16'd4 || csi.tilde_number == 16'd8) begin
                        emit          = 1'b1;
                        item.key_code = KEY_END;
                     end else if (csi.tilde_number == 16'd3) begin
                        emit          = 1'b1;
                        item.key_code = KEY_DELETE;
                     end
                  end
                  BYTE_UPPER_M, BYTE_LOWER_M: begin
                     if (lt_report) begin
                        emit             = 1'b1;
                        item.key_code    = KEY_MOUSE;
                        item.button_code = csi.acc_button;
                        item.pointer_col = csi.acc_col;
                        item.pointer_row = csi.acc_row;
                        item.is_release  = (byte_in == BYTE_LOWER_M);
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end else begin
               held_next = held + HeldWidth'(1);
               if (!csi.tilde_done) begin
                  if (is_digit) begin
                     csi_next.tilde_number = sat_digit(csi.tilde_number, digit_val);
                  end else begin
                     csi_next.tilde_done = 1'b1;
                  end
               end
               if (held == '0) begin
                  if (byte_in == BYTE_LT) begin
                     csi_next.starts_with_lt = 1'b1;
                  end
               end else if (csi.starts_with_lt && csi.mouse_phase != PHASE_STOP) begin
                  if (is_digit) begin
                     case (csi.mouse_phase)
                        PHASE_BUTTON: begin
                           csi_next.acc_button = sat_digit(csi.acc_button, digit_val);
                        end
                        PHASE_COL: begin
                           csi_next.acc_col = sat_digit(csi.acc_col, digit_val);
                        end
                        default: begin
                           csi_next.acc_row = sat_digit(csi.acc_row, digit_val);
                        end
                     endcase
                  end else if (byte_in == BYTE_SEMI) begin
                     case (csi.mouse_phase)
                        PHASE_BUTTON: csi_next.mouse_phase = PHASE_COL;
                        PHASE_COL:    csi_next.mouse_phase = PHASE_ROW;
                        default:      csi_next.mouse_phase = PHASE_STOP;
                     endcase
                  end else begin
                     csi_next.mouse_phase = PHASE_STOP;
                  end
               end
            end
         end

         default: begin
            mode_next = MODE_PLAIN;
         end
      endcase
   end

endmodule

FILE: rtl/vt100_input_key_parser_core.sv
// ----------------------------------------------------------------------------
// vt100_input_key_parser_core
// Decodes a raw terminal byte stream into key and SGR mouse events.
// ----------------------------------------------------------------------------
// The parser accepts one byte per clock cycle and produces at most one event
// per byte. A byte is captured in an input register and is
// decoded against the parser state once the result register is
// free or is being emptied; its event (if any) is then written to
// the result register, where it stays until the consumer takes it.
// The decode is a single short pass of compares and a saturating
// multiply-by-ten-and-add on 16-bit numbers, so the sustained rate is one byte
// per cycle; it drops only while the result register holds an event that the
// consumer does not take in that cycle. Bytes that give no event (ESC, the
// body of a CSI sequence, unknown control bytes) simply update the parser
// state. CSI_CAPACITY bounds the length of a CSI sequence: once
// CSI_CAPACITY-1 bytes of body have been taken, the next byte drops the
// sequence without an event. Decimal fields (the tilde code and the mouse
// button, column and row) saturate at 65535. There are no configuration
// registers and no startup sweep: the byte side is held not ready while reset
// is high and is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module vt100_input_key_parser_core #(
   parameter int CSI_CAPACITY = 32
) (
   input logic       clock,
   input logic       reset,
   vkp_req_if.sink   req_bus,
   vkp_rsp_if.source rsp_bus
);
   import vkp_pkg::*;

   localparam int HeldWidth = $clog2(CSI_CAPACITY);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Parser state.
   parse_mode_type         mode_ff, mode_in;
   logic [HeldWidth-1:0]   held_ff, held_in;
   csi_state_type          csi_ff, csi_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic         step_emit;
   logic         advance;

   // The buffered byte moves on whenever the result register is free or is
   // being emptied in this cycle; the input register refills in the same edge.
   // No byte is taken while reset is high, since it would be lost.
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !reset && (!in_valid_ff || advance);
   assign in_valid_in   = req_bus.valid || (in_valid_ff && !advance);

   vkp_step #(
      .CSI_CAPACITY (CSI_CAPACITY)
   ) u_step (
      .byte_in   (in_byte_ff),
      .mode      (mode_ff),
      .held      (held_ff),
      .csi       (csi_ff),
      .mode_next (mode_in),
      .held_next (held_in),
      .csi_next  (csi_in),
      .emit      (step_emit),
      .item      (rsp_item_in)
   );

   assign rsp_valid_in = advance ? step_emit : (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_PLAIN;
         held_ff      <= '0;
         csi_ff       <= CSI_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff <= mode_in;
            held_ff <= held_in;
            csi_ff  <= csi_in;
         end
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         in_byte_ff <= req_bus.byte_in;
      end
      if (advance && step_emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.key_code    = rsp_item_ff.key_code;
   assign rsp_bus.text_char   = rsp_item_ff.text_char;
   assign rsp_bus.button_code = rsp_item_ff.button_code;
   assign rsp_bus.pointer_col = rsp_item_ff.pointer_col;
   assign rsp_bus.pointer_row = rsp_item_ff.pointer_row;
   assign rsp_bus.is_release  = rsp_item_ff.is_release;

   // A nonzero byte count only exists inside an open CSI sequence.
   assert property (@(posedge clock) disable iff (reset)
      (held_ff != '0) |-> (mode_ff == MODE_CSI))
      else $error("CSI byte count nonzero outside a CSI sequence");

   // ESC mode lasts exactly one decoded byte.
   assert property (@(posedge clock) disable iff (reset)
      (advance && mode_ff == MODE_ESC) |=> (mode_ff != MODE_ESC))
      else $error("parser stayed in ESC mode after decoding a byte");

   // A buffered byte that cannot move on must stay put.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte was lost or changed");

   // Only text events carry a character, only mouse events carry coordinates.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_item_ff.key_code == KEY_TEXT || rsp_item_ff.text_char == 8'd0) &&
          (rsp_item_ff.key_code == KEY_MOUSE ||
           (rsp_item_ff.button_code == 16'd0 && rsp_item_ff.pointer_col == 16'd0 &&
            rsp_item_ff.pointer_row == 16'd0 && !rsp_item_ff.is_release))))
      else $error("event carries fields that do not belong to its key code");

endmodule
